>>> src/spd_pkg.sv
// Shared constants, types and codes of the slotted page directory.
package spd_pkg;

	localparam int PAGE_BYTES    = 4096;
	localparam int SLOT_CAPACITY = 1024;
	localparam int HDR_BYTES     = 4;
	localparam int SLOT_BYTES    = 4;

	localparam int SLOT_W  = $clog2(SLOT_CAPACITY);
	localparam int COUNT_W = $clog2(SLOT_CAPACITY + 1);
	localparam int PTR_W   = $clog2(PAGE_BYTES + 1);
	localparam int OFF_W   = $clog2(PAGE_BYTES);
	localparam int LEN_W   = 13;
	localparam int OP_W    = 3;
	localparam int ST_W    = 2;
	localparam int DIR_W   = $clog2(PAGE_BYTES + HDR_BYTES + SLOT_BYTES * SLOT_CAPACITY + 1);
	localparam int CMP_W   = (DIR_W > LEN_W + 1) ? DIR_W : LEN_W + 1;

	typedef enum logic [OP_W-1:0] {
		OP_INSERT = 3'd0,
		OP_GET    = 3'd1,
		OP_UPDATE = 3'd2,
		OP_DELETE = 3'd3,
		OP_INIT   = 3'd4
	} op_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK      = 2'd0,
		ST_NOSPACE = 2'd1,
		ST_RANGE   = 2'd2,
		ST_DELETED = 2'd3
	} status_t;

	typedef enum logic {
		S_IDLE,
		S_EXEC
	} fsm_t;

	typedef struct packed {
		logic [OFF_W-1:0] off;
		logic [LEN_W-1:0] len;
	} entry_t;

endpackage

>>> src/slotted_page_directory.sv
// Slotted page directory: slot table memory, free pointer and request sequencer.
//
//   channel   direction  handshake            word
//   cfg       in         cfg_write            cfg_data (header_base)
//   req       in         req_valid/req_stall  opcode, slot_id, record_length
//   rsp       out        rsp_valid/rsp_stall  status .. free_bytes
//
// In S_IDLE a request is taken and its directory entry is read from the single-port
// slot table; in S_EXEC it is decided, the entry is written back and the pointers updated.
// A request is taken while the previous response still waits; it then holds in S_EXEC
// until the response register is free. Reset empties the page at once.
// The slot table is not cleared; only entries below the slot count are ever used.
module slotted_page_directory (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_write,
	input  logic [spd_pkg::OFF_W-1:0]    cfg_data,
	input  logic                         req_valid,
	output logic                         req_stall,
	input  logic [spd_pkg::OP_W-1:0]     opcode,
	input  logic [spd_pkg::SLOT_W-1:0]   slot_id,
	input  logic [spd_pkg::LEN_W-1:0]    record_length,
	output logic                         rsp_valid,
	input  logic                         rsp_stall,
	output logic [spd_pkg::ST_W-1:0]     status,
	output logic [spd_pkg::SLOT_W-1:0]   slot_number,
	output logic [spd_pkg::OFF_W-1:0]    record_offset,
	output logic [spd_pkg::LEN_W-1:0]    length_out,
	output logic [spd_pkg::COUNT_W-1:0]  slot_count,
	output logic [spd_pkg::PTR_W-1:0]    free_bytes
);
	import spd_pkg::*;

	fsm_t                state_q, state_n;
	logic [OFF_W-1:0]    header_base_q;
	logic [COUNT_W-1:0]  used_q, used_n;
	logic [PTR_W-1:0]    fp_q, fp_n;

	entry_t              dir_mem [SLOT_CAPACITY];
	entry_t              rd_s1;
	logic                wr_en;
	logic [SLOT_W-1:0]   wr_addr;
	entry_t              wr_data;

	op_t                 op_s1;
	logic [SLOT_W-1:0]   sid_s1;
	logic [LEN_W-1:0]    len_s1;
	logic [PTR_W-1:0]    free_s1;
	logic                in_range_s1;
	logic                room_s1;

	logic                accept;
	logic                exec_go;
	logic                rsp_valid_q;
	status_t             status_q, status_n;
	logic [SLOT_W-1:0]   slot_q, slot_n;
	logic [OFF_W-1:0]    off_q, off_n;
	logic [LEN_W-1:0]    len_q, len_n;

	logic [DIR_W-1:0]    dir_end;
	logic [PTR_W-1:0]    free_now;
	logic [CMP_W-1:0]    need_ins;
	logic [PTR_W-1:0]    fp_dec;

	// Free space between the end of the directory and the free pointer, floored at zero.
	always_comb begin
		dir_end = DIR_W'(header_base_q) + DIR_W'(HDR_BYTES) + DIR_W'(used_q) * DIR_W'(SLOT_BYTES);
		if (DIR_W'(fp_q) > dir_end) begin
			free_now = PTR_W'(DIR_W'(fp_q) - dir_end);
		end else begin
			free_now = '0;
		end
	end

	assign accept    = req_valid && !req_stall;
	assign req_stall = (state_q != S_IDLE);
	assign exec_go   = (state_q == S_EXEC) && !(rsp_valid_q && rsp_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_base_q <= '0;
		end else if (cfg_write) begin
			header_base_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rd_s1 <= dir_mem[slot_id];
		end
		if (wr_en) begin
			dir_mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1       <= op_t'(opcode);
			sid_s1      <= slot_id;
			len_s1      <= record_length;
			free_s1     <= free_now;
			in_range_s1 <= (COUNT_W'(slot_id) < used_q);
			room_s1     <= (used_q < COUNT_W'(SLOT_CAPACITY));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			used_q      <= '0;
			fp_q        <= PTR_W'(PAGE_BYTES);
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (exec_go) begin
				used_q      <= used_n;
				fp_q        <= fp_n;
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (exec_go) begin
			status_q <= status_n;
			slot_q   <= slot_n;
			off_q    <= off_n;
			len_q    <= len_n;
		end
	end

	always_comb begin
		state_n = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_n = S_EXEC;
				end
			end
			S_EXEC: begin
				if (exec_go) begin
					state_n = S_IDLE;
				end
			end
			default: state_n = S_IDLE;
		endcase
	end

	// Decision, write-back and response for the request held in S_EXEC.
	always_comb begin
		need_ins = CMP_W'(len_s1) + CMP_W'(SLOT_BYTES);
		fp_dec   = PTR_W'(fp_q - PTR_W'(len_s1));
		used_n   = used_q;
		fp_n     = fp_q;
		wr_en    = 1'b0;
		wr_addr  = sid_s1;
		wr_data  = rd_s1;
		status_n = ST_OK;
		slot_n   = sid_s1;
		off_n    = '0;
		len_n    = '0;
		case (op_s1)
			OP_INSERT: begin
				if (room_s1 && (CMP_W'(free_s1) >= need_ins)) begin
					fp_n         = fp_dec;
					used_n       = COUNT_W'(used_q + COUNT_W'(1));
					wr_addr      = used_q[SLOT_W-1:0];
					wr_data.off  = fp_dec[OFF_W-1:0];
					wr_data.len  = len_s1;
					slot_n       = used_q[SLOT_W-1:0];
					off_n        = fp_dec[OFF_W-1:0];
					len_n        = len_s1;
				end else begin
					status_n = ST_NOSPACE;
					slot_n   = '0;
				end
			end
			OP_GET: begin
				if (!in_range_s1) begin
					status_n = ST_RANGE;
				end else if (rd_s1.len == '0) begin
					status_n = ST_DELETED;
					off_n    = rd_s1.off;
				end else begin
					off_n = rd_s1.off;
					len_n = rd_s1.len;
				end
			end
			OP_UPDATE: begin
				if (!in_range_s1) begin
					status_n = ST_RANGE;
				end else if (rd_s1.len >= len_s1) begin
					// Shrinking or equal length keeps the record where it is.
					wr_en       = 1'b1;
					wr_data.len = len_s1;
					off_n       = rd_s1.off;
					len_n       = len_s1;
				end else if (CMP_W'(free_s1) < CMP_W'(len_s1)) begin
					status_n = ST_NOSPACE;
					off_n    = rd_s1.off;
					len_n    = rd_s1.len;
				end else begin
					fp_n        = fp_dec;
					wr_en       = 1'b1;
					wr_data.off = fp_dec[OFF_W-1:0];
					wr_data.len = len_s1;
					off_n       = fp_dec[OFF_W-1:0];
					len_n       = len_s1;
				end
			end
			OP_DELETE: begin
				if (!in_range_s1) begin
					status_n = ST_RANGE;
				end else begin
					wr_en       = 1'b1;
					wr_data.len = '0;
					off_n       = rd_s1.off;
				end
			end
			OP_INIT: begin
				used_n = '0;
				fp_n   = PTR_W'(PAGE_BYTES);
				slot_n = '0;
			end
			default: begin
			end
		endcase
		// Insert writes the new slot only when it succeeds.
		if (op_s1 == OP_INSERT) begin
			wr_en = (status_n == ST_OK);
		end
		wr_en = wr_en && exec_go;
	end

	// Occupancy fields follow the pointer registers, which hold while a response waits.
	assign rsp_valid     = rsp_valid_q;
	assign status        = status_q;
	assign slot_number   = slot_q;
	assign record_offset = off_q;
	assign length_out    = len_q;
	assign slot_count    = used_q;
	assign free_bytes    = free_now;

endmodule
